// ===== rtl/core/dvrt_pkg.sv =====
// Shared types and constants for the route table.
// No dependencies.
`default_nettype none
package dvrt_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_SWEEP  = 2'd2;
    localparam logic [1:0] MODE_DUMP   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_IMPROVED  = 3'd2;
    localparam logic [2:0] ST_IGNORED   = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    localparam logic CFG_MAX_HOPS  = 1'b0;
    localparam logic CFG_EXPIRY_MS = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [55:0] dest_addr;
        logic [7:0]  advert_hops;
        logic [55:0] neighbor_addr;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [55:0] next_hop;
        logic [7:0]  entry_hops;
        logic [55:0] entry_dest;
        logic [8:0]  removed_count;
        logic        last;
    } rsp_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        match_en;
        logic        sweep;
        logic        write;
        logic        improve;
        logic        stamp;
        logic [IDX_W-1:0] slot;
    } cell_cmd_t;

    // per cell status, one per cell, gathered into an array by the top level
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic        expired;
        logic [55:0] hop;
        logic [7:0]  count;
        logic [55:0] dest;
    } cell_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/dvrt_cell.sv =====
// One table slot: entry storage, destination match and age check.
// Depends on dvrt_pkg.
`default_nettype none
module dvrt_cell (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [dvrt_pkg::IDX_W-1:0] my_idx,
    input  wire dvrt_pkg::cell_cmd_t    cmd,
    input  wire dvrt_pkg::req_t         req,
    input  wire logic [15:0]            expiry_ms,
    output dvrt_pkg::cell_stat_t        stat
);
    import dvrt_pkg::*;

    logic        valid_reg;
    logic [55:0] dest_reg, hop_reg;
    logic [7:0]  count_reg;
    logic [31:0] stamp_reg;
    logic [31:0] age;
    logic        sel;

    assign age = req.now_ms - stamp_reg;
    assign sel = (cmd.slot == my_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.sweep && valid_reg && age > {16'd0, expiry_ms}) begin
            valid_reg <= 1'b0;
        end else if (cmd.write && sel) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel && (cmd.write || cmd.improve)) begin
            hop_reg   <= req.neighbor_addr;
            count_reg <= req.advert_hops + 8'd1;
        end
        if (sel && cmd.write) begin
            dest_reg <= req.dest_addr;
        end
        if (sel && (cmd.write || cmd.improve || cmd.stamp)) begin
            stamp_reg <= req.now_ms;
        end
    end

    always_comb begin
        stat.valid   = valid_reg;
        stat.hit     = valid_reg && cmd.match_en && dest_reg == req.dest_addr;
        stat.expired = valid_reg && age > {16'd0, expiry_ms};
        stat.hop     = hop_reg;
        stat.count   = count_reg;
        stat.dest    = dest_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/core/distance_vector_route_table.sv =====
// Top level of the route table: a row of slot cells and the request sequencer.
// Depends on dvrt_pkg and dvrt_cell.
// Each request goes through a registered match state then a result state. An
// update, lookup or sweep result is registered in the result state once the
// output register can load. A dump gives one result per valid entry (at least
// 1) after the match, the final one marked last. s_ready is high only in the
// idle state, so a new request is not taken before the last one is done. The
// output register lets the next request be taken while a result waits.
`default_nettype none
module distance_vector_route_table (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire dvrt_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output dvrt_pkg::rsp_t      m_data,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [15:0]    cfg_data
);
    import dvrt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_DUMP  = 2'd3;

    logic [1:0] state_reg, state_next;
    req_t req_reg;
    logic [7:0]  max_hops_reg;
    logic [15:0] expiry_reg;
    cell_cmd_t cmd;
    cell_stat_t stat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_v, valid_v, exp_v, hit_reg, dump_left_reg;
    logic [IDX_W-1:0] hit_idx, free_idx, dump_idx;
    logic any_free;
    logic [CNT_W-1:0] rm_cnt;
    logic [8:0] hops9;
    rsp_t rsp_next;
    logic out_load;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dvrt_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .my_idx(IDX_W'(g)), .cmd(cmd),
                .req(req_reg), .expiry_ms(expiry_reg), .stat(stat[g])
            );
            assign hit_v[g]   = stat[g].hit;
            assign valid_v[g] = stat[g].valid;
            assign exp_v[g]   = stat[g].expired;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hops_reg <= 8'd32;
            expiry_reg   <= 16'd3000;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MAX_HOPS) max_hops_reg <= cfg_data[7:0];
            else expiry_reg <= cfg_data;
        end
    end

    always_comb begin
        hit_idx = '0; free_idx = '0; any_free = 1'b0; dump_idx = '0; rm_cnt = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (hit_reg[i]) hit_idx = IDX_W'(i);
            if (!valid_v[i]) begin free_idx = IDX_W'(i); any_free = 1'b1; end
            if (dump_left_reg[i]) dump_idx = IDX_W'(i);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) rm_cnt = rm_cnt + CNT_W'(exp_v[i]);
    end

    assign hops9 = {1'b0, req_reg.advert_hops} + 9'd1;
    assign s_ready = (state_reg == S_IDLE);
    assign out_load = !m_valid || m_ready;

    always_comb begin
        cmd = '0;
        cmd.match_en = (state_reg == S_MATCH);
        rsp_next = '0;
        rsp_next.status = ST_DONE;
        rsp_next.last = 1'b1;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_MATCH;
            S_MATCH: state_next = (req_reg.mode == MODE_DUMP) ? S_DUMP : S_EXEC;
            S_EXEC: if (out_load) begin
                state_next = S_IDLE;
                case (req_reg.mode)
                    MODE_UPDATE: begin
                        if (hops9 > {1'b0, max_hops_reg}) begin
                            rsp_next.status = ST_REJECTED;
                        end else if (|hit_reg) begin
                            cmd.slot = hit_idx;
                            if ({1'b0, stat[hit_idx].count} > hops9) begin
                                cmd.improve = 1'b1;
                                rsp_next.status = ST_IMPROVED;
                            end else if ({1'b0, stat[hit_idx].count} == hops9) begin
                                cmd.stamp = 1'b1;
                                rsp_next.status = ST_REFRESHED;
                            end else begin
                                rsp_next.status = ST_IGNORED;
                            end
                        end else if (any_free) begin
                            cmd.slot = free_idx;
                            cmd.write = 1'b1;
                            rsp_next.status = ST_INSERTED;
                        end else begin
                            rsp_next.status = ST_FULL;
                        end
                    end
                    MODE_LOOKUP: if (|hit_reg) begin
                        rsp_next.found = 1'b1;
                        rsp_next.next_hop = stat[hit_idx].hop;
                    end
                    MODE_SWEEP: begin
                        cmd.sweep = 1'b1;
                        rsp_next.removed_count = 9'(rm_cnt);
                    end
                    default: ;
                endcase
            end
            S_DUMP: if (out_load) begin
                if (|dump_left_reg) begin
                    rsp_next.found = 1'b1;
                    rsp_next.next_hop = stat[dump_idx].hop;
                    rsp_next.entry_hops = stat[dump_idx].count;
                    rsp_next.entry_dest = stat[dump_idx].dest;
                    rsp_next.last = (dump_left_reg & ~(TABLE_DEPTH'(1) << dump_idx)) == '0;
                end
                if (rsp_next.last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_EXEC || state_reg == S_DUMP) && out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        if (state_reg == S_MATCH) begin
            hit_reg       <= hit_v;
            dump_left_reg <= valid_v;
        end else if (state_reg == S_DUMP && out_load) begin
            dump_left_reg <= dump_left_reg & ~(TABLE_DEPTH'(1) << dump_idx);
        end
        if ((state_reg == S_EXEC || state_reg == S_DUMP) && out_load) m_data <= rsp_next;
    end

    a_onehot_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EXEC |-> $onehot0(hit_reg))
        else $error("duplicate destination in table");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped");
endmodule
`default_nettype wire

// ===== verif/distance_vector_route_table_tb.sv =====
// Testbench for distance_vector_route_table: directed and random requests with a route predictor.
// Depends on dvrt_pkg and the route table RTL.
`timescale 1ns / 100ps
module distance_vector_route_table_tb;
    import dvrt_pkg::*;

    localparam int EXP_DEPTH = 8192;
    localparam int KNOWN_DEPTH = 41;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_MAX_HOPS;
    logic [15:0] cfg_data = '0;

    distance_vector_route_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // predictor state
    logic [7:0]  pred_max_hops;
    logic [15:0] pred_expiry;
    logic        route_valid [TABLE_DEPTH];
    logic [55:0] route_dest [TABLE_DEPTH];
    logic [55:0] route_hop [TABLE_DEPTH];
    logic [7:0]  route_count [TABLE_DEPTH];
    logic [31:0] route_stamp [TABLE_DEPTH];

    rsp_t expected_rsp [EXP_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_off = 0;
    logic [55:0] known_dests [KNOWN_DEPTH];
    int   known_n = 0;

    function automatic void exp_put(rsp_t r);
        if (exp_wr >= EXP_DEPTH) begin
            $display("%0t expected result store overflow", $time);
            errors++;
        end else begin
            expected_rsp[exp_wr] = r;
            exp_wr++;
        end
    endfunction

    function automatic rsp_t blank_rsp();
        rsp_t r;
        r = '0;
        r.status = ST_DONE;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_route(logic [55:0] d);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (route_valid[i] && route_dest[i] == d) return i;
        return -1;
    endfunction

    task automatic predict_routes(req_t q);
        rsp_t r;
        logic [8:0] hops;
        logic [31:0] age;
        int slot;
        int n;
        r = blank_rsp();
        hops = {1'b0, q.advert_hops} + 9'd1;
        case (q.mode)
            MODE_UPDATE: begin
                if (hops > {1'b0, pred_max_hops}) begin
                    r.status = ST_REJECTED;
                end else begin
                    slot = find_route(q.dest_addr);
                    if (slot >= 0) begin
                        if ({1'b0, route_count[slot]} > hops) begin
                            route_count[slot] = hops[7:0];
                            route_hop[slot] = q.neighbor_addr;
                            route_stamp[slot] = q.now_ms;
                            r.status = ST_IMPROVED;
                        end else if ({1'b0, route_count[slot]} == hops) begin
                            route_stamp[slot] = q.now_ms;
                            r.status = ST_REFRESHED;
                        end else begin
                            r.status = ST_IGNORED;
                        end
                    end else begin
                        slot = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            if (!route_valid[i] && slot < 0) slot = i;
                        if (slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            route_valid[slot] = 1'b1;
                            route_dest[slot] = q.dest_addr;
                            route_hop[slot] = q.neighbor_addr;
                            route_count[slot] = hops[7:0];
                            route_stamp[slot] = q.now_ms;
                            r.status = ST_INSERTED;
                        end
                    end
                end
                exp_put(r);
            end
            MODE_LOOKUP: begin
                slot = find_route(q.dest_addr);
                if (slot >= 0) begin
                    r.found = 1'b1;
                    r.next_hop = route_hop[slot];
                end
                exp_put(r);
            end
            MODE_SWEEP: begin
                n = 0;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    age = q.now_ms - route_stamp[i];
                    if (route_valid[i] && age > {16'd0, pred_expiry}) begin
                        route_valid[i] = 1'b0;
                        n++;
                    end
                end
                r.removed_count = n[8:0];
                exp_put(r);
            end
            default: begin
                n = 0;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (route_valid[i]) begin
                        r = '0;
                        r.status = ST_DONE;
                        r.found = 1'b1;
                        r.next_hop = route_hop[i];
                        r.entry_hops = route_count[i];
                        r.entry_dest = route_dest[i];
                        exp_put(r);
                        n++;
                    end
                end
                if (n == 0) exp_put(blank_rsp());
                else if (exp_wr > 0) expected_rsp[exp_wr - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic send_request(req_t q);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_routes(q);
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (aresetn && m_valid && m_ready) begin
            if (exp_rd >= exp_wr) begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_data);
                errors++;
            end else begin
                if (m_data !== expected_rsp[exp_rd]) begin
                    $display("%0t mismatch: expected %h, actual %h",
                             $time, expected_rsp[exp_rd], m_data);
                    errors++;
                end
                exp_rd++;
            end
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (exp_rd < exp_wr) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_config(logic idx, logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_HOPS) pred_max_hops = v[7:0];
        else pred_expiry = v;
    endtask

    function automatic logic [55:0] rand_addr();
        return 56'({$urandom(), $urandom()});
    endfunction

    function automatic req_t make_req(logic [1:0] m, logic [55:0] d, logic [7:0] h,
                                      logic [55:0] nb, logic [31:0] t);
        req_t q;
        q.mode = m;
        q.dest_addr = d;
        q.advert_hops = h;
        q.neighbor_addr = nb;
        q.now_ms = t;
        return q;
    endfunction

    task automatic test_directed();
        send_request(make_req(MODE_DUMP, '0, 8'd0, '0, 32'd0));
        send_request(make_req(MODE_LOOKUP, '1, 8'd0, '0, 32'd0));
        send_request(make_req(MODE_UPDATE, '1, 8'd5, '1, 32'hffff_fff0));
        send_request(make_req(MODE_UPDATE, '1, 8'd5, 56'h1, 32'h10));
        send_request(make_req(MODE_UPDATE, '1, 8'd2, 56'h2, 32'h20));
        send_request(make_req(MODE_UPDATE, '1, 8'd9, 56'h3, 32'h30));
        send_request(make_req(MODE_UPDATE, '0, 8'd31, '1, 32'd0));
        send_request(make_req(MODE_UPDATE, 56'h5, 8'd32, '1, 32'd0));
        send_request(make_req(MODE_UPDATE, 56'h6, 8'd255, '1, 32'd0));
        send_request(make_req(MODE_LOOKUP, '1, 8'hff, '1, '1));
        send_request(make_req(MODE_DUMP, '1, 8'hff, '1, '1));
        send_request(make_req(MODE_SWEEP, '0, 8'd0, '0, 32'd3030));
        send_request(make_req(MODE_SWEEP, '0, 8'd0, '0, 32'd3031));
        send_request(make_req(MODE_DUMP, '0, 8'd0, '0, 32'd0));
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_request(make_req(MODE_UPDATE, 56'h100 + 56'(i), 8'd1, rand_addr(), 32'd100));
        send_request(make_req(MODE_DUMP, '0, 8'd0, '0, 32'd0));
        send_request(make_req(MODE_SWEEP, '0, 8'd0, '0, 32'h8000_0000));
    endtask

    task automatic test_random(int count);
        req_t q;
        int sel;
        logic [31:0] clock_ms;
        clock_ms = $urandom();
        for (int k = 0; k < count; k++) begin
            clock_ms += 32'($urandom_range(400));
            sel = $urandom_range(99);
            q = make_req(MODE_UPDATE, rand_addr(), 8'($urandom()), rand_addr(), clock_ms);
            if (known_n == 0 || $urandom_range(3) == 0) begin
                q.dest_addr = {52'd0, 4'($urandom_range(15))} ^ (($urandom_range(9) == 0)
                              ? rand_addr() : 56'd0);
                known_dests[known_n] = q.dest_addr;
                known_n++;
            end else begin
                q.dest_addr = known_dests[$urandom_range(known_n - 1)];
            end
            if ($urandom_range(3) != 0) q.advert_hops = 8'($urandom_range(40));
            if (sel < 60) q.mode = MODE_UPDATE;
            else if (sel < 80) q.mode = MODE_LOOKUP;
            else if (sel < 90) q.mode = MODE_SWEEP;
            else q.mode = MODE_DUMP;
            if (q.mode == MODE_SWEEP && $urandom_range(4) == 0) q.now_ms = $urandom();
            send_request(q);
            if (known_n > KNOWN_DEPTH - 1) known_n = 0;
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 20; i++)
            send_request(make_req(MODE_LOOKUP, 56'h100 + 56'(i), 8'd0, '0, 32'd0));
    endtask

    initial begin
        pred_max_hops = 8'd32;
        pred_expiry = 16'd3000;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            route_valid[i] = 1'b0;
            route_dest[i] = '0;
            route_hop[i] = '0;
            route_count[i] = '0;
            route_stamp[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 23;
        recv_idle_pct = 78;
        test_directed();
        test_table_full();
        write_config(CFG_MAX_HOPS, 16'd1);
        write_config(CFG_EXPIRY_MS, 16'd1);
        send_request(make_req(MODE_UPDATE, 56'h77, 8'd0, 56'h9, 32'd5));
        send_request(make_req(MODE_UPDATE, 56'h78, 8'd1, 56'h9, 32'd5));
        send_request(make_req(MODE_SWEEP, '0, 8'd0, '0, 32'd6));
        send_request(make_req(MODE_SWEEP, '0, 8'd0, '0, 32'd8));
        test_random(90);
        send_idle_pct = 78;
        recv_idle_pct = 23;
        write_config(CFG_MAX_HOPS, 16'd254);
        write_config(CFG_EXPIRY_MS, 16'd65535);
        test_random(90);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(CFG_MAX_HOPS, 16'd0);
        test_random(30);
        write_config(CFG_MAX_HOPS, 16'd20);
        write_config(CFG_EXPIRY_MS, 16'd700);
        test_random(110);
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
